FILE: rtl/core/varint_length_frame_deframer_assert.svh
// Assertion macros shared by the deframer's checker.
// Each macro expands to one labeled concurrent assertion that is disabled during reset.
`ifndef VARINT_LENGTH_FRAME_DEFRAMER_ASSERT_SVH
`define VARINT_LENGTH_FRAME_DEFRAMER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define VLFD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define VLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/vlfd_pkg.sv
// ----------------------------------------------------------------------------
// vlfd_pkg
// Shared types and constants of the varint length-prefixed frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vlfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int LEN_W      = 28;
    localparam int GROUP_W    = 7;
    localparam int LEN_GROUPS = LEN_W / GROUP_W;

    localparam logic [KIND_W-1:0] KIND_HEAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LENGTH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BODY   = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [KIND_W-1:0] byte_kind;
        logic              frame_last;
        logic              length_valid;
        logic [LEN_W-1:0]  body_length;
        logic [BYTE_W-1:0] length_xor;
        logic              length_error;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/vlfd_in_stage.sv
// ----------------------------------------------------------------------------
// vlfd_in_stage
// Input register that holds one received word until the parser takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlfd_in_stage
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [vlfd_pkg::BYTE_W-1:0] rx_byte,
    input  wire logic                       advance,
    output logic                            held_valid,
    output logic [vlfd_pkg::BYTE_W-1:0]     held_byte
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [vlfd_pkg::BYTE_W-1:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/vlfd_parser.sv
// ----------------------------------------------------------------------------
// vlfd_parser
// Frame state machine: tags each word and decodes the varint body length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlfd_parser
#(
    parameter int MAX_LENGTH_BYTES = 4
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [vlfd_pkg::BYTE_W-1:0] cur_byte,
    output vlfd_pkg::result_t                result
);

    localparam int CW = $clog2(MAX_LENGTH_BYTES + 1);
    localparam int LW = vlfd_pkg::LEN_W;

    typedef enum logic [1:0] {
        PH_HEAD   = 2'd0,
        PH_CHECK  = 2'd1,
        PH_LENGTH = 2'd2,
        PH_BODY   = 2'd3
    } phase_t;

    phase_t                      phase_reg;
    phase_t                      phase_next;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [LW-1:0]               acc_reg;
    logic [LW-1:0]               acc_next;
    logic [LW-1:0]               remain_reg;
    logic [LW-1:0]               remain_next;
    logic [vlfd_pkg::BYTE_W-1:0] xor_reg;
    logic [vlfd_pkg::BYTE_W-1:0] xor_next;

    logic [CW+1:0]               count_ext;
    logic [CW-1:0]               count_inc;
    logic [LW-1:0]               group_bits;
    logic [LW-1:0]               acc_sum;
    logic [vlfd_pkg::BYTE_W-1:0] xor_sum;
    logic [LW-1:0]               remain_dec;

    assign count_ext = (CW + 2)'(count_reg);
    assign count_inc = count_reg + CW'(1);
    assign xor_sum   = xor_reg ^ cur_byte;
    assign remain_dec = remain_reg - LW'(remain_reg != '0);

    // Groups beyond the 28-bit length are dropped. Lower groups land on zero
    // bits of the accumulator, so OR-ing them in is the same as adding.
    always_comb
    begin
        group_bits = '0;
        if (int'(count_ext) < vlfd_pkg::LEN_GROUPS)
        begin
            case (count_ext[1:0])
                2'd0:    group_bits = LW'({cur_byte[6:0]});
                2'd1:    group_bits = LW'({cur_byte[6:0], 7'd0});
                2'd2:    group_bits = LW'({cur_byte[6:0], 14'd0});
                default: group_bits = {cur_byte[6:0], 21'd0};
            endcase
        end
    end

    assign acc_sum = acc_reg | group_bits;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        remain_next = remain_reg;
        xor_next    = xor_reg;

        result              = '0;
        result.out_byte     = cur_byte;

        case (phase_reg)
            PH_HEAD:
            begin
                result.byte_kind = vlfd_pkg::KIND_HEAD;
                phase_next       = PH_CHECK;
                count_next       = '0;
                acc_next         = '0;
                remain_next      = '0;
                xor_next         = '0;
            end
            PH_CHECK:
            begin
                result.byte_kind = vlfd_pkg::KIND_CHECK;
                phase_next       = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                result.byte_kind = vlfd_pkg::KIND_LENGTH;
                acc_next         = acc_sum;
                xor_next         = xor_sum;
                count_next       = count_inc;
                if (!cur_byte[7])
                begin
                    result.length_valid = 1'b1;
                    result.body_length  = acc_sum;
                    result.length_xor   = xor_sum;
                    if (acc_sum == '0)
                    begin
                        result.frame_last = 1'b1;
                        phase_next        = PH_HEAD;
                        count_next        = '0;
                        acc_next          = '0;
                        remain_next       = '0;
                        xor_next          = '0;
                    end
                    else
                    begin
                        remain_next = acc_sum;
                        phase_next  = PH_BODY;
                    end
                end
                else if (count_inc >= CW'(MAX_LENGTH_BYTES))
                begin
                    // Overlong length: drop the frame and hunt for a new head.
                    result.length_error = 1'b1;
                    result.frame_last   = 1'b1;
                    result.length_xor   = xor_sum;
                    phase_next          = PH_HEAD;
                    count_next          = '0;
                    acc_next            = '0;
                    remain_next         = '0;
                    xor_next            = '0;
                end
            end
            PH_BODY:
            begin
                result.byte_kind = vlfd_pkg::KIND_BODY;
                remain_next      = remain_dec;
                if (remain_dec == '0)
                begin
                    result.frame_last = 1'b1;
                    phase_next        = PH_HEAD;
                    count_next        = '0;
                    acc_next          = '0;
                    xor_next          = '0;
                end
            end
            default:
            begin
                phase_next = PH_HEAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD;
            count_reg  <= '0;
            acc_reg    <= '0;
            remain_reg <= '0;
            xor_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            acc_reg    <= acc_next;
            remain_reg <= remain_next;
            xor_reg    <= xor_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/vlfd_out_stage.sv
// ----------------------------------------------------------------------------
// vlfd_out_stage
// Result register that holds one tagged word until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlfd_out_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   advance,
    input  wire vlfd_pkg::result_t src_result,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output vlfd_pkg::result_t      out_result
);

    logic              valid_reg;
    logic              valid_next;
    vlfd_pkg::result_t result_reg;

    assign advance    = src_valid && (!valid_reg || out_ready);
    assign valid_next = advance || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= src_result;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/varint_length_frame_deframer.sv
// ----------------------------------------------------------------------------
// varint_length_frame_deframer
// Splits a byte stream into head, check, varint length and body words.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready with rx_byte, one received word per transfer.
// Output channel: out_valid / out_ready with the word passed through, its kind,
// the frame end mark, and on the terminating length word the decoded body length
// and the XOR of the length words. An overlong length raises length_error.
// Every input word gives exactly one output word, in order.
// An accepted word is held in the input register; as it advances, the frame state
// machine updates and the result register loads, and out_valid then rises.
// Throughput is one word per cycle while the receiver keeps out_ready high.
// The input register takes a new word while a finished result still waits, so a
// stalled receiver backs the stream up by two words before in_ready drops.
// Reset empties both registers and returns the parser to expecting a head word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module varint_length_frame_deframer
#(
    parameter int MAX_LENGTH_BYTES = 4
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [vlfd_pkg::BYTE_W-1:0] rx_byte,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [vlfd_pkg::BYTE_W-1:0]      out_byte,
    output logic [vlfd_pkg::KIND_W-1:0]      byte_kind,
    output logic                             frame_last,
    output logic                             length_valid,
    output logic [vlfd_pkg::LEN_W-1:0]       body_length,
    output logic [vlfd_pkg::BYTE_W-1:0]      length_xor,
    output logic                             length_error
);

    logic                        advance;
    logic                        held_valid;
    logic [vlfd_pkg::BYTE_W-1:0] held_byte;
    vlfd_pkg::result_t           step_result;
    vlfd_pkg::result_t           out_result;

    vlfd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    vlfd_parser #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .cur_byte (held_byte),
        .result   (step_result)
    );

    vlfd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (held_valid),
        .advance    (advance),
        .src_result (step_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign out_byte     = out_result.out_byte;
    assign byte_kind    = out_result.byte_kind;
    assign frame_last   = out_result.frame_last;
    assign length_valid = out_result.length_valid;
    assign body_length  = out_result.body_length;
    assign length_xor   = out_result.length_xor;
    assign length_error = out_result.length_error;

endmodule

`default_nettype wire

FILE: rtl/core/vlfd_checker.sv
// ----------------------------------------------------------------------------
// vlfd_checker
// Port-level checks of the deframer's output word stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "varint_length_frame_deframer_assert.svh"

module vlfd_checker
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [vlfd_pkg::BYTE_W-1:0] out_byte,
    input wire logic [vlfd_pkg::KIND_W-1:0] byte_kind,
    input wire logic                        frame_last,
    input wire logic                        length_valid,
    input wire logic                        length_error
);

    // A length report and a length error never share a word.
    `VLFD_ASSERT_ALWAYS(a_len_excl, clk, rst_n, !(out_valid && length_valid && length_error), "length_valid and length_error both set")

    // Length flags only appear on length words.
    `VLFD_ASSERT_ALWAYS(a_len_kind, clk, rst_n, !(out_valid && (length_valid || length_error)) || (byte_kind == vlfd_pkg::KIND_LENGTH), "length flag on a non-length word")

    // An aborted frame always ends on the offending word.
    `VLFD_ASSERT_ALWAYS(a_err_last, clk, rst_n, !(out_valid && length_error) || frame_last, "length_error without frame_last")

    // A head word never closes a frame.
    `VLFD_ASSERT_ALWAYS(a_head_open, clk, rst_n, !(out_valid && (byte_kind == vlfd_pkg::KIND_HEAD)) || !frame_last, "frame_last on a head word")

    // A stalled output word stays valid with its byte and kind unchanged.
    `VLFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(byte_kind), "output word changed while stalled")

endmodule

bind varint_length_frame_deframer vlfd_checker u_vlfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_kind    (byte_kind),
    .frame_last   (frame_last),
    .length_valid (length_valid),
    .length_error (length_error)
);

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the varint length-prefixed frame deframer.
// A directed table walks through the boundary frames: empty body, overlong
// length, padded length encodings and one-byte bodies. Random well-formed frames
// with random content follow, mixed with overlong lengths. Every word is checked
// against an in-bench frame parser or a typed table row, under three idling mixes
// and one long receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int          MAX_LEN_BYTES = 4;
    localparam int          PHASE_BYTES   = 465;
    localparam int          STALL_CYCLES  = 400;
    localparam int unsigned CYCLE_LIMIT   = 300000;

    typedef enum logic [1:0] {PH_HEAD, PH_CHECK, PH_LENGTH, PH_BODY} frame_phase_t;

    typedef struct {
        logic [vlfd_pkg::BYTE_W-1:0] b;
        bit                          typed;
        vlfd_pkg::result_t           exp;
    } stim_t;

    localparam vlfd_pkg::result_t NO_EXP = '0;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_ready;
    logic [vlfd_pkg::BYTE_W-1:0] rx_byte      = '0;
    logic                        out_valid;
    logic                        out_ready    = 1'b0;
    logic [vlfd_pkg::BYTE_W-1:0] out_byte;
    logic [vlfd_pkg::KIND_W-1:0] byte_kind;
    logic                        frame_last;
    logic                        length_valid;
    logic [vlfd_pkg::LEN_W-1:0]  body_length;
    logic [vlfd_pkg::BYTE_W-1:0] length_xor;
    logic                        length_error;

    // Parser copy: phase and length decoding state of the frame in progress.
    frame_phase_t                frm_phase   = PH_HEAD;
    logic [2:0]                  len_cnt     = '0;
    logic [vlfd_pkg::LEN_W-1:0]  len_acc     = '0;
    logic [vlfd_pkg::LEN_W-1:0]  body_left   = '0;
    logic [vlfd_pkg::BYTE_W-1:0] len_xor_acc = '0;

    stim_t             send_q[$];
    vlfd_pkg::result_t expect_q[$];

    int unsigned send_idle     = 0;
    int unsigned recv_idle     = 0;
    int unsigned err_count     = 0;
    int unsigned words_seen    = 0;
    int unsigned cycles        = 0;
    int unsigned stall_left    = 0;
    bit          pressure_arm  = 1'b0;
    bit          pressure_done = 1'b0;

    // Rows with typed expectations are the ones readable straight off the frame
    // layout; the rest are predicted.
    stim_t dir_tab [25] = '{
        '{8'h00, 1'b1, '{8'h00, vlfd_pkg::KIND_HEAD,   1'b0, 1'b0, 28'd0, 8'h00, 1'b0}},
        '{8'hFF, 1'b1, '{8'hFF, vlfd_pkg::KIND_CHECK,  1'b0, 1'b0, 28'd0, 8'h00, 1'b0}},
        '{8'h00, 1'b1, '{8'h00, vlfd_pkg::KIND_LENGTH, 1'b1, 1'b1, 28'd0, 8'h00, 1'b0}},
        '{8'hFF, 1'b0, NO_EXP},
        '{8'h00, 1'b0, NO_EXP},
        '{8'h80, 1'b0, NO_EXP},
        '{8'h80, 1'b0, NO_EXP},
        '{8'h80, 1'b0, NO_EXP},
        '{8'hFF, 1'b1, '{8'hFF, vlfd_pkg::KIND_LENGTH, 1'b1, 1'b0, 28'd0, 8'h7F, 1'b1}},
        '{8'hA5, 1'b0, NO_EXP},
        '{8'h5A, 1'b0, NO_EXP},
        '{8'h01, 1'b1, '{8'h01, vlfd_pkg::KIND_LENGTH, 1'b0, 1'b1, 28'd1, 8'h01, 1'b0}},
        '{8'hFF, 1'b1, '{8'hFF, vlfd_pkg::KIND_BODY,   1'b1, 1'b0, 28'd0, 8'h00, 1'b0}},
        '{8'h3C, 1'b0, NO_EXP},
        '{8'hC3, 1'b0, NO_EXP},
        '{8'h82, 1'b0, NO_EXP},
        '{8'h00, 1'b0, NO_EXP},
        '{8'h00, 1'b0, NO_EXP},
        '{8'h7F, 1'b0, NO_EXP},
        '{8'h11, 1'b0, NO_EXP},
        '{8'h22, 1'b0, NO_EXP},
        '{8'h80, 1'b0, NO_EXP},
        '{8'h80, 1'b0, NO_EXP},
        '{8'h80, 1'b0, NO_EXP},
        '{8'h00, 1'b0, NO_EXP}
    };

    varint_length_frame_deframer #(
        .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_kind    (byte_kind),
        .frame_last   (frame_last),
        .length_valid (length_valid),
        .body_length  (body_length),
        .length_xor   (length_xor),
        .length_error (length_error)
    );

    always #5 clk = ~clk;

    function automatic void restart_frame();
        frm_phase   = PH_HEAD;
        len_cnt     = '0;
        len_acc     = '0;
        body_left   = '0;
        len_xor_acc = '0;
    endfunction

    function automatic vlfd_pkg::result_t deframe_byte(input logic [vlfd_pkg::BYTE_W-1:0] b);
        vlfd_pkg::result_t r;
        r          = '0;
        r.out_byte = b;
        case (frm_phase)
            PH_HEAD:
            begin
                r.byte_kind = vlfd_pkg::KIND_HEAD;
                restart_frame();
                frm_phase = PH_CHECK;
            end
            PH_CHECK:
            begin
                r.byte_kind = vlfd_pkg::KIND_CHECK;
                frm_phase   = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                r.byte_kind = vlfd_pkg::KIND_LENGTH;
                // Groups above bit 27 drop out; the 28-bit sum wraps on its own.
                if (len_cnt < vlfd_pkg::LEN_GROUPS)
                begin
                    len_acc = len_acc + (vlfd_pkg::LEN_W'(b[vlfd_pkg::GROUP_W-1:0])
                                         << (vlfd_pkg::GROUP_W * len_cnt));
                end
                len_xor_acc = len_xor_acc ^ b;
                len_cnt     = len_cnt + 3'd1;
                if (!b[7])
                begin
                    r.length_valid = 1'b1;
                    r.body_length  = len_acc;
                    r.length_xor   = len_xor_acc;
                    if (len_acc == '0)
                    begin
                        r.frame_last = 1'b1;
                        restart_frame();
                    end
                    else
                    begin
                        body_left = len_acc;
                        frm_phase = PH_BODY;
                    end
                end
                else if (len_cnt >= MAX_LEN_BYTES)
                begin
                    r.length_error = 1'b1;
                    r.frame_last   = 1'b1;
                    r.length_xor   = len_xor_acc;
                    restart_frame();
                end
            end
            default:
            begin
                r.byte_kind = vlfd_pkg::KIND_BODY;
                if (body_left != '0)
                begin
                    body_left = body_left - 1'b1;
                end
                if (body_left == '0)
                begin
                    r.frame_last = 1'b1;
                    restart_frame();
                end
            end
        endcase
        return r;
    endfunction

    task automatic add_stim(input stim_t s);
        send_q = {send_q, s};
    endtask

    task automatic add_expect(input vlfd_pkg::result_t r);
        expect_q = {expect_q, r};
    endtask

    task automatic queue_byte(input logic [vlfd_pkg::BYTE_W-1:0] b);
        stim_t s;
        s = '{b, 1'b0, NO_EXP};
        add_stim(s);
    endtask

    // Mostly well-formed frames with short bodies, sometimes padded length
    // encodings, and about one in ten with an overlong length.
    task automatic queue_frame();
        int unsigned pick;
        int unsigned blen;
        int unsigned n_groups;
        int unsigned n_bytes;
        logic [6:0]  grp;
        queue_byte(8'($urandom));
        queue_byte(8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            for (int i = 0; i < MAX_LEN_BYTES; i++)
            begin
                queue_byte({1'b1, 7'($urandom)});
            end
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 15)
            blen = 0;
        else if (pick < 75)
            blen = $urandom_range(1, 12);
        else if (pick < 96)
            blen = $urandom_range(13, 200);
        else
            blen = $urandom_range(201, 300);
        n_groups = 1;
        while ((blen >> (vlfd_pkg::GROUP_W * n_groups)) != 0)
        begin
            n_groups++;
        end
        n_bytes = ($urandom_range(0, 3) == 0) ? $urandom_range(n_groups, MAX_LEN_BYTES)
                                              : n_groups;
        for (int i = 0; i < n_bytes; i++)
        begin
            grp = 7'(blen >> (vlfd_pkg::GROUP_W * i));
            queue_byte({(i != n_bytes - 1) ? 1'b1 : 1'b0, grp});
        end
        for (int i = 0; i < blen; i++)
        begin
            queue_byte(8'($urandom));
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch on word %0d, %s: got 0x%0h, expected 0x%0h",
                 words_seen, what, got, want);
        err_count++;
    endtask

    // Sender: offers the next word when the channel is free, predicting each
    // word at the edge where it is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                stim_t             s;
                vlfd_pkg::result_t r;
                s = send_q.pop_front();
                r = deframe_byte(rx_byte);
                add_expect(s.typed ? s.exp : r);
            end
            if (!in_valid || in_ready)
            begin
                if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= send_q[0].b;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver stall, armed once in the last phase.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
            end
            else if (pressure_arm && !pressure_done)
            begin
                stall_left    <= STALL_CYCLES;
                pressure_done <= 1'b1;
            end
        end
    end

    // Receiver: checks each word taken, and drives out_ready with random idling.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                vlfd_pkg::result_t want;
                if (expect_q.size() == 0)
                begin
                    report("word with nothing expected", {24'd0, out_byte}, 32'd0);
                end
                else
                begin
                    want = expect_q.pop_front();
                    if (out_byte !== want.out_byte)
                        report("out_byte", 32'(out_byte), 32'(want.out_byte));
                    if (byte_kind !== want.byte_kind)
                        report("byte_kind", 32'(byte_kind), 32'(want.byte_kind));
                    if (frame_last !== want.frame_last)
                        report("frame_last", 32'(frame_last), 32'(want.frame_last));
                    if (length_valid !== want.length_valid)
                        report("length_valid", 32'(length_valid), 32'(want.length_valid));
                    if (body_length !== want.body_length)
                        report("body_length", 32'(body_length), 32'(want.body_length));
                    if (length_xor !== want.length_xor)
                        report("length_xor", 32'(length_xor), 32'(want.length_xor));
                    if (length_error !== want.length_error)
                        report("length_error", 32'(length_error), 32'(want.length_error));
                end
                words_seen++;
            end
            if (stall_left != 0 || (pressure_arm && !pressure_done))
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 3; ph++)
        begin
            @(negedge clk);
            case (ph)
                0:
                begin
                    send_idle = 31;
                    recv_idle = 84;
                end
                1:
                begin
                    send_idle = 84;
                    recv_idle = 31;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            if (ph == 0)
            begin
                foreach (dir_tab[i])
                begin
                    add_stim(dir_tab[i]);
                end
            end
            // With no idling, a long stall on the output backs the block up
            // until in_ready drops.
            if (ph == 2)
            begin
                pressure_arm = 1'b1;
            end
            while (send_q.size() < PHASE_BYTES)
            begin
                queue_frame();
            end
            while (send_q.size() != 0 || in_valid || expect_q.size() != 0)
            begin
                @(negedge clk);
            end
        end
        repeat (8) @(negedge clk);
        if (err_count == 0 && expect_q.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
